// ===== hdl/ssd_pkg.sv =====
// ssd_pkg: shared types, constants and helpers of the silence span detector
// no dependencies; imported by every other file of the block
`default_nettype none

package ssd_pkg;

  // width of the tick counter and of the run start register
  localparam int TIME_BITS = 32;
  // width of the span fields on the result channel
  localparam int SPAN_W    = 32;
  // width of the configuration write data and of the minimum length register
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 16;
  localparam int SAMPLE_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICKS   = CFG_IDX_W'(2);

  // sample formats
  localparam logic MODE_U8  = 1'b0;
  localparam logic MODE_S16 = 1'b1;

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [SPAN_W-1:0]    span_word_t;

  // result of the run tracker for one word
  typedef struct packed {
    logic       emit;
    span_word_t span_start;
    span_word_t span_end;
  } trk_res_t;

  // low span bits of a tick value, zero extended when the counter is narrow
  function automatic span_word_t to_span(input tick_t t);
    logic [TIME_BITS+SPAN_W-1:0] w;
    w = {{SPAN_W{1'b0}}, t};
    return w[SPAN_W-1:0];
  endfunction

  // run length against the minimum, both zero extended to a common width
  function automatic logic long_enough(input tick_t len, input logic [CFG_W-1:0] min_len);
    logic [TIME_BITS+CFG_W-1:0] l;
    logic [TIME_BITS+CFG_W-1:0] m;
    l = {{CFG_W{1'b0}}, len};
    m = {{TIME_BITS{1'b0}}, min_len};
    return l >= m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ssd_if.sv =====
// ssd_in_if and ssd_out_if: valid/ready channels of the silence span detector
// depends on ssd_pkg for the payload widths
`default_nettype none

interface ssd_in_if import ssd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_bits;
  logic                end_of_clip;

  modport source (output valid, output sample_bits, output end_of_clip, input ready);
  modport sink   (input valid, input sample_bits, input end_of_clip, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ();
  logic       valid;
  logic       ready;
  span_word_t span_start;
  span_word_t span_end;

  modport source (output valid, output span_start, output span_end, input ready);
  modport sink   (input valid, input span_start, input span_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/ssd_mag.sv =====
// ssd_mag: q0.16 magnitude of one sample and the silence decision
// depends on ssd_pkg
`default_nettype none

module ssd_mag import ssd_pkg::*; (
  input  wire logic                sample_mode,
  input  wire logic [SAMPLE_W-1:0] sample_bits,
  input  wire logic [THR_W-1:0]    threshold,
  output logic                     silent
);

  logic [8:0]       twice;
  logic [8:0]       dist9;
  logic [THR_W-1:0] mag_u8;
  logic [16:0]      abs17;
  logic [THR_W-1:0] mag_s16;
  logic [THR_W-1:0] mag;

  // 8-bit mode: |2u - 255| * 257 is the distance byte repeated
  always_comb begin
    twice = {sample_bits[7:0], 1'b0};
    if (twice >= 9'd255) begin
      dist9 = twice - 9'd255;
    end else begin
      dist9 = 9'd255 - twice;
    end
    mag_u8 = {dist9[7:0], dist9[7:0]};
  end

  // 16-bit mode: |s| * 2, saturated at full scale
  always_comb begin
    if (sample_bits[SAMPLE_W-1]) begin
      abs17 = 17'h10000 - {1'b0, sample_bits};
    end else begin
      abs17 = {1'b0, sample_bits};
    end
    if (abs17[16] || abs17[15]) begin
      mag_s16 = '1;
    end else begin
      mag_s16 = {abs17[14:0], 1'b0};
    end
  end

  assign mag    = (sample_mode == MODE_U8) ? mag_u8 : mag_s16;
  assign silent = (mag <= threshold);

endmodule

`default_nettype wire

// ===== hdl/ssd_tracker.sv =====
// ssd_tracker: tick counter, open run state and span decision
// depends on ssd_pkg
`default_nettype none

module ssd_tracker import ssd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             silent,
  input  wire logic             last,
  input  wire logic [CFG_W-1:0] min_ticks,
  output trk_res_t              res
);

  tick_t tick_r, tick_nxt;
  logic  open_r, open_nxt;
  tick_t start_r, start_nxt;

  tick_t tick_inc;
  logic  open_mid;
  tick_t start_mid;

  // span decision and next state for the word in the input register
  always_comb begin
    res       = '0;
    open_mid  = open_r;
    start_mid = start_r;
    tick_inc  = (tick_r == '1) ? tick_r : tick_r + 1'b1;

    if (silent && !open_r) begin
      open_mid  = 1'b1;
      start_mid = tick_r;
    end else if (!silent && open_r) begin
      if (long_enough(tick_r - start_r, min_ticks)) begin
        res.emit       = 1'b1;
        res.span_start = to_span(start_r);
        res.span_end   = to_span(tick_r);
      end
      open_mid = 1'b0;
    end

    tick_nxt  = tick_inc;
    open_nxt  = open_mid;
    start_nxt = start_mid;

    // clip end flushes an open run and restarts at tick zero
    if (last) begin
      if (open_mid && long_enough(tick_inc - start_mid, min_ticks)) begin
        res.emit       = 1'b1;
        res.span_start = to_span(start_mid);
        res.span_end   = to_span(tick_inc);
      end
      tick_nxt  = '0;
      open_nxt  = 1'b0;
      start_nxt = '0;
    end
  end

  // state update when the word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
    end else if (advance) begin
      tick_r  <= tick_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
    end
  end

  // an open run never starts after the current tick
  a_start_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (start_r <= tick_r))
    else $error("run start lies after the tick counter");

  // clip end leaves the tracker cleared
  a_clip_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last) |=> (tick_r == '0 && !open_r && start_r == '0))
    else $error("tracker not cleared after clip end");

  // no span without a run behind it
  a_emit_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |-> (open_r || (last && silent)))
    else $error("span raised with no open run");

endmodule

`default_nettype wire

// ===== hdl/silence_span_detector.sv =====
// silence_span_detector: top level with configuration registers, input and
// result registers; depends on ssd_pkg, ssd_if, ssd_mag and ssd_tracker
`default_nettype none

// Finds runs of quiet audio: one sample word per tick, a span word (first
// silent tick, first loud tick or clip-end tick) for each run at least as
// long as the minimum length register. A word sits in the input register,
// where the magnitude, threshold compare and run update are done, and a span
// goes to the result register. One word is taken every cycle; the only stall
// is a span that meets a result register still held by the sink. A span is
// loaded into the result register when its word leaves the input register.
// Configuration must be written through cfg_we/cfg_index/cfg_wdata only
// while no word is in flight; the block itself does not enforce this.
module silence_span_detector import ssd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ssd_in_if.sink                    in_ch,
  ssd_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic             mode_r;
  logic [THR_W-1:0] thr_r;
  logic [CFG_W-1:0] min_r;

  logic                s1_v_r, s1_v_nxt;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_last_r;

  logic       out_v_r, out_v_nxt;
  span_word_t out_start_r;
  span_word_t out_end_r;

  logic     silent;
  trk_res_t res;
  logic     out_free;
  logic     s1_adv;
  logic     in_take;
  logic     out_ld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_S16;
      thr_r  <= '0;
      min_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_MODE: mode_r <= cfg_wdata[0];
        CFG_THRESHOLD:   thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_MIN_TICKS:   min_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // flow control between the two registers
  assign out_free     = !out_v_r || out_ch.ready;
  assign s1_adv       = s1_v_r && (!res.emit || out_free);
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ld       = s1_adv && res.emit;

  always_comb begin
    s1_v_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = out_ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_ch.sample_bits;
      s1_last_r   <= in_ch.end_of_clip;
    end
  end

  ssd_mag u_mag (
    .sample_mode (mode_r),
    .sample_bits (s1_sample_r),
    .threshold   (thr_r),
    .silent      (silent)
  );

  ssd_tracker u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_adv),
    .silent    (silent),
    .last      (s1_last_r),
    .min_ticks (min_r),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_start_r <= res.span_start;
      out_end_r   <= res.span_end;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.span_start = out_start_r;
  assign out_ch.span_end   = out_end_r;

  // a new result only comes from a word held in the input register
  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !$past(out_v_r)) |-> $past(s1_v_r))
    else $error("result appeared without a word in the input register");

  // a stuck word in the input register blocks the input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> !in_ch.ready)
    else $error("input taken while the input register is stuck");

  // a span is only held back by an occupied, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> (res.emit && out_v_r && !out_ch.ready))
    else $error("input register stalled with no cause");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench of silence_span_detector, with a span predictor
// depends on ssd_pkg, ssd_if (ssd_in_if, ssd_out_if) and the block itself
`timescale 1ns / 100ps

module tb;
  import ssd_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);

  localparam int WORDS_PER_PHASE = 180;
  localparam int HOLD_AT         = 250;
  localparam int HOLD_CYCLES     = 300;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // sample words at the corners of both formats
  localparam logic [5:0][15:0] CORNER_WORDS = {
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0080, 16'hFF7F
  };

  typedef struct packed {
    span_word_t first_quiet;
    span_word_t first_loud;
  } span_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [SAMPLE_W-1:0]   sample;
    logic                  last;
    logic                  typed;
    logic                  has_span;
    span_t                 fixed;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ssd_in_if  samples_if ();
  ssd_out_if spans_if ();

  silence_span_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (samples_if),
    .out_ch    (spans_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and its copy of the registers
  tick_t                tick_q;
  logic                 run_q;
  tick_t                run_from_q;
  logic                 mode_q;
  logic [THR_W-1:0]     thr_q;
  logic [CFG_W-1:0]     min_q;

  span_t pending_spans[$];
  int    faults;
  int    words_accepted;
  int    spans_seen;
  int    settings_applied;
  logic  held_once;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("** silence_span_detector: FAILED **");
    $finish;
  end

  // Q0.16 magnitude of a raw word in the current format
  function automatic logic [15:0] loudness(input logic [SAMPLE_W-1:0] raw);
    logic [8:0]  twice;
    logic [7:0]  dev;
    logic [15:0] abs_s;
    logic [16:0] mag;
    if (mode_q == MODE_U8) begin
      twice = {raw[7:0], 1'b0};
      dev = (twice >= 9'd255) ? 8'(twice - 9'd255) : 8'(9'd255 - twice);
      return 16'(dev) * 16'd257;
    end
    abs_s = raw[15] ? 16'(17'h10000 - {1'b0, raw}) : raw;
    mag = {abs_s, 1'b0};
    return (mag > 17'h0FFFF) ? 16'hFFFF : mag[15:0];
  endfunction

  function automatic logic long_run(input tick_t len);
    logic [63:0] l;
    logic [63:0] m;
    l = 64'(len);
    m = 64'(min_q);
    return l >= m;
  endfunction

  // one accepted word through the run tracker
  task automatic span_predict(input logic [SAMPLE_W-1:0] raw, input logic last,
                              output logic made, output span_t sp);
    tick_t now;
    logic  quiet;
    made = 1'b0;
    sp = '0;
    now = tick_q;
    quiet = loudness(raw) <= thr_q;
    if (quiet && !run_q) begin
      run_q = 1'b1;
      run_from_q = now;
    end else if (!quiet && run_q) begin
      if (long_run(now - run_from_q)) begin
        made = 1'b1;
        sp.first_quiet = span_word_t'(run_from_q);
        sp.first_loud = span_word_t'(now);
      end
      run_q = 1'b0;
    end
    // counter sticks at its top value
    if (tick_q != '1) tick_q = tick_q + 1'b1;
    // clip end flushes an open run and starts the next clip at tick 0
    if (last) begin
      if (run_q && long_run(tick_q - run_from_q)) begin
        made = 1'b1;
        sp.first_quiet = span_word_t'(run_from_q);
        sp.first_loud = span_word_t'(tick_q);
      end
      tick_q = '0;
      run_q = 1'b0;
      run_from_q = '0;
    end
  endtask

  // random word of the wanted class under the current format and threshold
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic want_quiet);
    logic [SAMPLE_W-1:0] cand;
    int spread;
    int v;
    int d;
    cand = '0;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 3))
        0: cand = 16'($urandom);
        1: begin
          // spread around silence
          if (mode_q == MODE_S16) begin
            spread = int'(thr_q) / 2 + 2;
            v = int'($urandom_range(0, 2 * spread)) - spread;
            cand = 16'(v);
          end else begin
            spread = int'(thr_q) / 514 + 2;
            v = 127 + int'($urandom_range(0, 2 * spread + 1)) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            cand = {8'($urandom), 8'(v)};
          end
        end
        2: cand = CORNER_WORDS[$urandom_range(0, 5)];
        default: begin
          // right on the threshold
          if (mode_q == MODE_S16) begin
            v = int'(thr_q) / 2 + int'($urandom_range(0, 2)) - 1;
            cand = $urandom_range(0, 1) ? 16'(-v) : 16'(v);
          end else begin
            d = int'(thr_q) / 257 + int'($urandom_range(0, 2)) - 1;
            v = $urandom_range(0, 1) ? (255 + d + 1) / 2 : (255 - d) / 2;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            cand = {8'($urandom), 8'(v)};
          end
        end
      endcase
      if ((loudness(cand) <= thr_q) == want_quiet) return cand;
    end
    return cand;
  endfunction

  function automatic stim_row_t word_row(input logic [SAMPLE_W-1:0] raw, input logic last,
                                         input logic typed, input logic has_span,
                                         input span_word_t a, input span_word_t b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.sample = raw;
    r.last = last;
    r.typed = typed;
    r.has_span = has_span;
    r.fixed.first_quiet = a;
    r.fixed.first_loud = b;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // queue a span the block owes us
  task automatic expect_span(input span_t sp);
    pending_spans.insert(pending_spans.size(), sp);
  endtask

  // span checker
  always @(posedge clk) begin : span_check
    span_t want;
    if (rst_n && spans_if.valid && spans_if.ready) begin
      spans_seen++;
      if (pending_spans.size() == 0) begin
        log_fault($sformatf("span %h..%h with none expected",
                            spans_if.span_start, spans_if.span_end));
      end else begin
        want = pending_spans.pop_front();
        if (spans_if.span_start !== want.first_quiet)
          log_fault($sformatf("span_start expected %h, got %h",
                              want.first_quiet, spans_if.span_start));
        if (spans_if.span_end !== want.first_loud)
          log_fault($sformatf("span_end expected %h, got %h",
                              want.first_loud, spans_if.span_end));
      end
    end
  end

  // span sink: stall patterns plus one long hold-off
  initial begin : span_sink
    int seg;
    int style;
    int hold_count;
    spans_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      style = $urandom_range(0, 2);
      seg = $urandom_range(16, 80);
      for (int n = 0; n < seg; n++) begin
        @(negedge clk);
        if (!held_once && words_accepted >= HOLD_AT) begin
          held_once = 1'b1;
          spans_if.ready <= 1'b0;
          for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        end
        case (style)
          0:       spans_if.ready <= 1'b1;
          1:       spans_if.ready <= ($urandom_range(0, 3) != 0);
          default: spans_if.ready <= ((n % 8) < 5);
        endcase
      end
    end
  end

  // word source
  int burst_left;

  // offer one word in bursts, then note what it should produce
  task automatic send_word(input logic [SAMPLE_W-1:0] raw, input logic last,
                           input logic typed, input logic has_span, input span_t fixed);
    int    gap;
    logic  made;
    span_t sp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    samples_if.valid <= 1'b1;
    samples_if.sample_bits <= raw;
    samples_if.end_of_clip <= last;
    do @(posedge clk); while (!samples_if.ready);
    words_accepted++;
    span_predict(raw, last, made, sp);
    if (typed) begin
      if (has_span) expect_span(fixed);
    end else if (made) begin
      expect_span(sp);
    end
    @(negedge clk);
  endtask

  // block idle: all spans in and the pipeline empty
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, caller lowers cfg_we afterwards
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_SAMPLE_MODE: mode_q = data[0];
      CFG_THRESHOLD:   thr_q = data[THR_W-1:0];
      CFG_MIN_TICKS:   min_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // one setting followed by well-formed runs with random content and some noise
  task automatic run_phase(input logic mode, input logic [THR_W-1:0] thr,
                           input logic [CFG_W-1:0] min_len);
    int base;
    int n_quiet;
    int n_loud;
    logic flush;
    drain();
    // upper bits of the narrow registers carry junk, which must be masked
    cfg_put(CFG_SAMPLE_MODE, {31'($urandom), mode});
    cfg_put(CFG_THRESHOLD, {16'($urandom), thr});
    cfg_put(CFG_MIN_TICKS, min_len);
    if ($urandom_range(0, 1)) cfg_put(CFG_SPARE_IDX, $urandom);
    cfg_we <= 1'b0;
    settings_applied++;
    base = words_accepted;
    while (words_accepted - base < WORDS_PER_PHASE) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(16'($urandom), ($urandom_range(0, 19) == 0), 1'b0, 1'b0, '0);
      end else begin
        n_quiet = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        n_loud = $urandom_range(1, 5);
        flush = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < n_quiet; k++)
          send_word(pick_sample(1'b1), flush && (k == n_quiet - 1), 1'b0, 1'b0, '0);
        if (!flush) begin
          for (int k = 0; k < n_loud; k++)
            send_word(pick_sample(1'b0), ($urandom_range(0, 29) == 0), 1'b0, 1'b0, '0);
        end
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    stim_row_t rows[$];
    samples_if.valid = 1'b0;
    samples_if.sample_bits = '0;
    samples_if.end_of_clip = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    mode_q = MODE_S16;
    thr_q = '0;
    min_q = '0;
    tick_q = '0;
    run_q = 1'b0;
    run_from_q = '0;
    faults = 0;
    words_accepted = 0;
    spans_seen = 0;
    settings_applied = 1;
    held_once = 1'b0;
    burst_left = 0;

    // reset defaults: 16-bit, threshold 0, no minimum
    rows.insert(rows.size(), word_row(16'h0000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0001, 1'b0, 1'b1, 1'b1, 32'd0, 32'd1));
    rows.insert(rows.size(), word_row(16'h8000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    // clip end flushes the open run
    rows.insert(rows.size(), word_row(16'h0000, 1'b1, 1'b1, 1'b1, 32'd3, 32'd4));
    rows.insert(rows.size(), word_row(16'h7FFF, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0));
    // 8-bit format, threshold 257, junk in the upper register bits, spare index
    rows.insert(rows.size(), cfg_row(CFG_SAMPLE_MODE, 32'hFFFF_FFFE));
    rows.insert(rows.size(), cfg_row(CFG_THRESHOLD, 32'hABCD_0101));
    rows.insert(rows.size(), cfg_row(CFG_SPARE_IDX, 32'hFFFF_FFFF));
    // upper byte ignored in 8-bit format
    rows.insert(rows.size(), word_row(16'hFF80, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h007F, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0000, 1'b0, 1'b1, 1'b1, 32'd0, 32'd2));
    rows.insert(rows.size(), word_row(16'h00FF, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    // largest minimum: short runs vanish
    rows.insert(rows.size(), cfg_row(CFG_MIN_TICKS, 32'hFFFF_FFFF));
    rows.insert(rows.size(), word_row(16'h1280, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0001, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0080, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), cfg_row(CFG_MIN_TICKS, 32'd2));
    rows.insert(rows.size(), word_row(16'h0080, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0080, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    // loud word closes the run on the clip-end word
    rows.insert(rows.size(), word_row(16'h0000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd2));
    // top threshold: everything is silent
    rows.insert(rows.size(), cfg_row(CFG_THRESHOLD, 32'h0000_FFFF));
    rows.insert(rows.size(), word_row(16'h00FF, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0));
    rows.insert(rows.size(), word_row(16'h0000, 1'b1, 1'b1, 1'b1, 32'd0, 32'd2));
    rows.insert(rows.size(), word_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        cfg_put(rows[i].idx, rows[i].data);
        cfg_we <= 1'b0;
        settings_applied++;
      end else begin
        send_word(rows[i].sample, rows[i].last, rows[i].typed, rows[i].has_span,
                  rows[i].fixed);
      end
    end

    run_phase(MODE_U8,  16'($urandom_range(257, 40000)), 32'($urandom_range(0, 4)));
    run_phase(MODE_S16, 16'($urandom_range(0, 2000)), 32'd0);
    run_phase(MODE_S16, 16'h0000, 32'd1);
    run_phase(MODE_U8,  16'hFFFF, 32'd0);
    run_phase(MODE_S16, 16'hFFFF, 32'hFFFF_FFFF);
    run_phase(MODE_U8,  16'($urandom_range(0, 256)), 32'd0);
    run_phase(MODE_S16, 16'($urandom), 32'($urandom_range(0, 20)));
    run_phase(MODE_U8,  16'($urandom), 32'($urandom_range(0, 8)));

    // let the last spans come out
    samples_if.valid <= 1'b0;
    for (int guard = 0; guard < 2000 && pending_spans.size() != 0; guard++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_spans.size() != 0) begin
      faults += pending_spans.size();
      $display("%0d expected spans never arrived", pending_spans.size());
    end

    $display("run covered %0d sample words under %0d register settings", words_accepted,
             settings_applied);
    $display("%0d spans checked, %0d faults found", spans_seen, faults);
    if (faults == 0) begin
      $display("** silence_span_detector: PASSED **");
    end else begin
      $display("** silence_span_detector: FAILED **");
    end
    $finish;
  end

endmodule
